@@ src/rtpc_pkg.sv @@
`timescale 1ns / 1ps

package rtpc_pkg;

    localparam int S_W           = 10;
    localparam int R_W           = 16;
    localparam int P_W           = 16;
    localparam int P_SIM_W       = S_W + 1;
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;

    localparam int PROD_W  = 2 * S_W;
    localparam int NUM_W   = PROD_W + R_W;
    localparam int P_SHIFT = 10;
    localparam int PN_W    = NUM_W - P_SHIFT;
    localparam int P_QB    = P_W;
    localparam int SC_W    = 2 * S_W;
    localparam int XQB     = S_W;

    localparam int S_A   = 0;
    localparam int S_B   = 1;
    localparam int S_C   = 2;
    localparam int S_D0  = 3;
    localparam int S_O   = S_D0 + P_QB + 1;
    localparam int N_STG = S_O + 1;

    localparam int IN_FIELDS = 7;
    localparam int IN_TD_W   = ((IN_FIELDS * S_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 2 * S_W + P_W;
    localparam int OUT_TD_W  = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RES   = 3'd0,
        REG_PORT  = 3'd1,
        REG_X_MIN = 3'd2,
        REG_X_MAX = 3'd3,
        REG_Y_MIN = 3'd4,
        REG_Y_MAX = 3'd5
    } t_reg_idx;

    localparam logic [R_W-1:0] RST_RES   = 16'd0;
    localparam logic           RST_PORT  = 1'b1;
    localparam logic [S_W-1:0] RST_X_MIN = 10'd0;
    localparam logic [S_W-1:0] RST_X_MAX = 10'd890;
    localparam logic [S_W-1:0] RST_Y_MIN = 10'd15;
    localparam logic [S_W-1:0] RST_Y_MAX = 10'd845;

    typedef struct packed {
        logic [R_W-1:0] res;
        logic           portrait;
        logic [S_W-1:0] x_min;
        logic [S_W-1:0] x_max;
        logic [S_W-1:0] y_min;
        logic [S_W-1:0] y_max;
    } t_cfg;

    typedef struct packed {
        logic [S_W-1:0] z1;
        logic [S_W-1:0] z2;
        logic [S_W-1:0] px;
        logic [S_W-1:0] xa;
        logic [S_W-1:0] xb;
        logic [S_W-1:0] ya;
        logic [S_W-1:0] yb;
    } t_stg_a;

    typedef struct packed {
        logic [S_W-1:0]     z1;
        logic               pos_ok;
        logic               p_zero;
        logic [P_SIM_W-1:0] p_simple;
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic [PROD_W-1:0] prod;
        logic [S_W-1:0]    nx;
        logic [S_W-1:0]    ny;
        logic [S_W-1:0]    dx;
        logic [S_W-1:0]    dy;
    } t_stg_b;

    typedef struct packed {
        t_ctl             ctl;
        logic [NUM_W-1:0] num;
        logic [SC_W-1:0]  snx;
        logic [SC_W-1:0]  sny;
        logic [S_W-1:0]   dx;
        logic [S_W-1:0]   dy;
    } t_stg_c;

    typedef struct packed {
        t_ctl            ctl;
        logic            sat;
        logic [PN_W-1:0] prem;
        logic [P_QB-1:0] pq;
        logic [SC_W-1:0] xrem;
        logic [XQB-1:0]  xq;
        logic [S_W-1:0]  xd;
        logic [SC_W-1:0] yrem;
        logic [XQB-1:0]  yq;
        logic [S_W-1:0]  yd;
    } t_div;

endpackage

@@ src/resistive_touch_point_calc_unit.sv @@
// Reset (synchronous, active low) clears all stage valid bits and loads register defaults.
// Throughput: one transaction per cycle unless the output stalls; depth is set by the
// 16-step restoring divider for pressure, with the two 10-step screen scaling dividers
// running beside it. Stalls back up stage by stage, so empty stages still take new
// transactions.
`timescale 1ns / 1ps

module resistive_touch_point_calc_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rtpc_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [rtpc_pkg::R_W-1:0]             i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // z1_sample, z2_sample, pressure_x_sample, x_sample_first, x_sample_second,
    // y_sample_first, y_sample_second, zero padding
    input  logic [rtpc_pkg::IN_TD_W-1:0]         s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // screen_x, screen_y, pressure_value, zero padding
    output logic [rtpc_pkg::OUT_TD_W-1:0]        m_axis_tdata,
    // touch_valid
    output logic [0:0]                           m_axis_tuser
);

    import rtpc_pkg::*;

    t_cfg               r_cfg;
    logic [N_STG-1:0]   r_vld;
    logic [N_STG:0]     w_rdy;

    t_stg_a             r_a;
    t_stg_a             n_a;
    t_stg_b             r_b;
    t_stg_b             n_b;
    t_stg_c             r_c;
    t_stg_c             n_c;
    t_div               r_dv [0:P_QB];
    t_div               n_dv [0:P_QB];
    logic [OUT_TD_W-1:0] r_o_data;
    logic [OUT_TD_W-1:0] n_o_data;
    logic               r_o_user;
    logic               n_o_user;

    logic [S_W-1:0]     w_dz;
    logic [PN_W-1:0]    w_pt [0:P_QB-1];
    logic [SC_W-1:0]    w_xt [0:P_QB-1];
    logic [SC_W-1:0]    w_yt [0:P_QB-1];
    logic [P_W-1:0]     w_pres;
    logic               w_ok;
    logic [S_W-1:0]     w_ox;
    logic [S_W-1:0]     w_oy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.res      <= RST_RES;
            r_cfg.portrait <= RST_PORT;
            r_cfg.x_min    <= RST_X_MIN;
            r_cfg.x_max    <= RST_X_MAX;
            r_cfg.y_min    <= RST_Y_MIN;
            r_cfg.y_max    <= RST_Y_MAX;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_RES:   r_cfg.res      <= i_cfg_wdata;
                REG_PORT:  r_cfg.portrait <= i_cfg_wdata[0];
                REG_X_MIN: r_cfg.x_min    <= i_cfg_wdata[S_W-1:0];
                REG_X_MAX: r_cfg.x_max    <= i_cfg_wdata[S_W-1:0];
                REG_Y_MIN: r_cfg.y_min    <= i_cfg_wdata[S_W-1:0];
                REG_Y_MAX: r_cfg.y_max    <= i_cfg_wdata[S_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage advances when empty or when the stage after it advances
    always_comb begin
        w_rdy[N_STG] = m_axis_tready;
        for (int k = N_STG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[S_A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[S_A]) r_vld[S_A] <= s_axis_tvalid;
            for (int k = 1; k < N_STG; k++) begin
                if (w_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // invert position samples
    always_comb begin
        n_a.z1 = s_axis_tdata[0*S_W +: S_W];
        n_a.z2 = s_axis_tdata[1*S_W +: S_W];
        n_a.px = ~s_axis_tdata[2*S_W +: S_W];
        n_a.xa = ~s_axis_tdata[3*S_W +: S_W];
        n_a.xb = ~s_axis_tdata[4*S_W +: S_W];
        n_a.ya = ~s_axis_tdata[5*S_W +: S_W];
        n_a.yb = ~s_axis_tdata[6*S_W +: S_W];
    end

    // checks and first product
    always_comb begin
        w_dz            = r_a.z2 - r_a.z1;
        n_b.ctl.z1      = r_a.z1;
        n_b.ctl.p_zero  = (r_a.z1 == '0) || (r_a.z2 <= r_a.z1);
        n_b.ctl.p_simple = P_SIM_W'(1023) + {1'b0, r_a.z1} - {1'b0, r_a.z2};
        n_b.ctl.pos_ok  = (r_a.xa == r_a.xb) && (r_a.ya == r_a.yb)
                          && (r_cfg.x_max > r_cfg.x_min) && (r_cfg.y_max > r_cfg.y_min)
                          && (r_a.xa >= r_cfg.x_min) && (r_a.xa <= r_cfg.x_max)
                          && (r_a.ya >= r_cfg.y_min) && (r_a.ya <= r_cfg.y_max);
        n_b.prod        = PROD_W'(w_dz) * PROD_W'(r_a.px);
        n_b.nx          = r_a.xa - r_cfg.x_min;
        n_b.ny          = r_a.ya - r_cfg.y_min;
        n_b.dx          = r_cfg.x_max - r_cfg.x_min;
        n_b.dy          = r_cfg.y_max - r_cfg.y_min;
    end

    // resistance product and screen scaling numerators
    always_comb begin
        n_c.ctl = r_b.ctl;
        n_c.num = NUM_W'(r_b.prod) * NUM_W'(r_cfg.res);
        n_c.snx = SC_W'(r_b.nx) * SC_W'(SCREEN_WIDTH);
        n_c.sny = SC_W'(r_b.ny) * SC_W'(SCREEN_HEIGHT);
        n_c.dx  = r_b.dx;
        n_c.dy  = r_b.dy;
    end

    // divider load and restoring steps, one quotient bit per stage
    always_comb begin
        n_dv[0].ctl  = r_c.ctl;
        n_dv[0].sat  = r_c.num[NUM_W-1:P_SHIFT] >= {r_c.ctl.z1, P_QB'(0)};
        n_dv[0].prem = r_c.num[NUM_W-1:P_SHIFT];
        n_dv[0].pq   = '0;
        n_dv[0].xrem = r_c.snx;
        n_dv[0].xq   = '0;
        n_dv[0].xd   = r_c.dx;
        n_dv[0].yrem = r_c.sny;
        n_dv[0].yq   = '0;
        n_dv[0].yd   = r_c.dy;
        for (int j = 0; j < P_QB; j++) begin
            n_dv[j+1] = r_dv[j];
            w_pt[j]   = PN_W'(r_dv[j].ctl.z1) << (P_QB - 1 - j);
            w_xt[j]   = '0;
            w_yt[j]   = '0;
            if (r_dv[j].prem >= w_pt[j]) begin
                n_dv[j+1].prem           = r_dv[j].prem - w_pt[j];
                n_dv[j+1].pq[P_QB-1-j]   = 1'b1;
            end
            if (j < XQB) begin
                w_xt[j] = SC_W'(r_dv[j].xd) << (XQB - 1 - j);
                w_yt[j] = SC_W'(r_dv[j].yd) << (XQB - 1 - j);
                if (r_dv[j].xrem >= w_xt[j]) begin
                    n_dv[j+1].xrem         = r_dv[j].xrem - w_xt[j];
                    n_dv[j+1].xq[XQB-1-j]  = 1'b1;
                end
                if (r_dv[j].yrem >= w_yt[j]) begin
                    n_dv[j+1].yrem         = r_dv[j].yrem - w_yt[j];
                    n_dv[j+1].yq[XQB-1-j]  = 1'b1;
                end
            end
        end
    end

    // pressure select, acceptance and orientation
    always_comb begin
        if (r_cfg.res == '0) begin
            w_pres = P_W'(r_dv[P_QB].ctl.p_simple);
        end else if (r_dv[P_QB].ctl.p_zero) begin
            w_pres = '0;
        end else if (r_dv[P_QB].sat) begin
            w_pres = '1;
        end else begin
            w_pres = r_dv[P_QB].pq;
        end
        w_ok = (w_pres != '0) && r_dv[P_QB].ctl.pos_ok;
        if (r_cfg.portrait) begin
            w_ox = r_dv[P_QB].yq;
            w_oy = S_W'(SCREEN_WIDTH) - r_dv[P_QB].xq;
        end else begin
            w_ox = r_dv[P_QB].xq;
            w_oy = r_dv[P_QB].yq;
        end
        n_o_user = w_ok;
        n_o_data = '0;
        if (w_ok) begin
            n_o_data = {(OUT_TD_W - OUT_RAW_W)'(0), w_pres, w_oy, w_ox};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_A]) r_a <= n_a;
        if (w_rdy[S_B]) r_b <= n_b;
        if (w_rdy[S_C]) r_c <= n_c;
        for (int k = 0; k <= P_QB; k++) begin
            if (w_rdy[S_D0+k]) r_dv[k] <= n_dv[k];
        end
        if (w_rdy[S_O]) begin
            r_o_data <= n_o_data;
            r_o_user <= n_o_user;
        end
    end

    assign m_axis_tvalid   = r_vld[S_O];
    assign m_axis_tdata    = r_o_data;
    assign m_axis_tuser[0] = r_o_user;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("rejected touch carries nonzero data");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> &r_vld)
        else $error("input blocked while a stage is empty");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[S_A])
        else $error("accepted transaction not captured");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_vld[S_O-1]))
        else $error("output valid without a finished divider stage");

endmodule

@@ bench/resistive_touch_point_calc_unit_tb.sv @@
`timescale 1ns / 1ps

module resistive_touch_point_calc_unit_tb;

    import rtpc_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RST_CYCLES     = 5;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RAND_PHASES    = 9;
    localparam int SETS_PER_PHASE = 190;
    localparam int HOLD_PHASE     = 2;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CFG_IDX_W-1:0] REG_VOID_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOID_B = 3'd7;

    localparam int RESET_SEL = 0;

    typedef struct packed {
        logic [S_W-1:0] yb;
        logic [S_W-1:0] ya;
        logic [S_W-1:0] xb;
        logic [S_W-1:0] xa;
        logic [S_W-1:0] px;
        logic [S_W-1:0] z2;
        logic [S_W-1:0] z1;
    } sample_set_t;

    typedef struct packed {
        logic           valid;
        logic [S_W-1:0] sx;
        logic [S_W-1:0] sy;
        logic [P_W-1:0] pr;
    } touch_res_t;

    typedef struct packed {
        logic       typed;
        touch_res_t res;
    } touch_tag_t;

    typedef struct packed {
        logic [2:0]  sel;
        sample_set_t s;
        logic        typed;
        touch_res_t  res;
    } touch_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [R_W-1:0]        i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TD_W-1:0]    s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0]   m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    t_cfg        model_cfg;
    t_cfg        dir_cfg [5];
    touch_row_t  touch_rows [$];
    touch_tag_t  set_tags [$];
    touch_res_t  touches_due [$];
    int          sets_sent    = 0;
    int          touches_seen = 0;
    int          err_count    = 0;
    int          idle_cycles  = 0;
    int          hold_left    = 0;
    int          rx_left      = 0;
    logic        hold_start   = 1'b0;
    logic        hold_taken   = 1'b0;
    logic        calm         = 1'b0;

    resistive_touch_point_calc_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic touch_res_t predict_touch(t_cfg c, sample_set_t s);
        longint unsigned z1, z2, px, num, den, pr;
        int         xa, xb, ya, yb, xmin, xmax, ymin, ymax, sx, sy;
        bit         ok;
        touch_res_t r;
        z1   = s.z1;
        z2   = s.z2;
        px   = 1023 - s.px;
        xa   = 1023 - s.xa;
        xb   = 1023 - s.xb;
        ya   = 1023 - s.ya;
        yb   = 1023 - s.yb;
        xmin = c.x_min;
        xmax = c.x_max;
        ymin = c.y_min;
        ymax = c.y_max;
        if (c.res == 0) begin
            pr = 1023 + z1 - z2;
        end else if (z1 == 0 || z2 <= z1) begin
            pr = 0;
        end else begin
            num = (z2 - z1) * px * c.res;
            den = z1 * 1024;
            pr  = num / den;
            if (pr > 65535)
                pr = 65535;
        end
        ok = (pr != 0) && (xa == xb) && (ya == yb) && (xmax > xmin) && (ymax > ymin);
        if (ok && (xa < xmin || xa > xmax || ya < ymin || ya > ymax))
            ok = 1'b0;
        r = '0;
        if (ok) begin
            sx = (xa - xmin) * SCREEN_WIDTH / (xmax - xmin);
            sy = (ya - ymin) * SCREEN_HEIGHT / (ymax - ymin);
            r.valid = 1'b1;
            if (c.portrait) begin
                r.sx = sy;
                r.sy = SCREEN_WIDTH - sx;
            end else begin
                r.sx = sx;
                r.sy = sy;
            end
            r.pr = pr;
        end
        return r;
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        case ($urandom_range(0, 4))
            0: c.res = 16'd0;
            1: c.res = 16'hFFFF;
            2: c.res = $urandom_range(1, 50);
            default: c.res = $urandom_range(0, 65535);
        endcase
        c.portrait = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) begin
            c.x_min = $urandom_range(0, 1023);
            c.x_max = $urandom_range(0, 1023);
            c.y_min = $urandom_range(0, 1023);
            c.y_max = $urandom_range(0, 1023);
        end else begin
            c.x_min = $urandom_range(0, 900);
            c.x_max = $urandom_range(c.x_min + 1, 1023);
            c.y_min = $urandom_range(0, 900);
            c.y_max = $urandom_range(c.y_min + 1, 1023);
        end
        return c;
    endfunction

    function automatic sample_set_t rand_set(t_cfg c);
        sample_set_t s;
        int          kind, xi, yi, z1;
        kind = $urandom_range(0, 9);
        xi   = (c.x_max >= c.x_min) ? $urandom_range(c.x_min, c.x_max) : $urandom_range(0, 1023);
        yi   = (c.y_max >= c.y_min) ? $urandom_range(c.y_min, c.y_max) : $urandom_range(0, 1023);
        if (kind == 9) begin
            if ($urandom_range(0, 1))
                xi = (c.x_max + 1) % 1024;
            else
                yi = (c.y_min + 1023) % 1024;
        end
        s.xa = 1023 - xi;
        s.xb = s.xa;
        s.ya = 1023 - yi;
        s.yb = s.ya;
        s.px = $urandom_range(0, 1023);
        if (c.res != 0) begin
            z1   = $urandom_range(1, 1022);
            s.z1 = z1;
            s.z2 = $urandom_range(z1 + 1, 1023);
        end else begin
            s.z1 = $urandom_range(0, 1023);
            s.z2 = $urandom_range(0, 1023);
        end
        if (kind == 7)
            s = {$urandom, $urandom, $urandom};
        if (kind == 8) begin
            if ($urandom_range(0, 1))
                s.xb[$urandom_range(0, S_W - 1)] ^= 1'b1;
            else
                s.yb[$urandom_range(0, S_W - 1)] ^= 1'b1;
        end
        return s;
    endfunction

    task automatic add_row(input int sel, input int z1, input int z2, input int px,
                           input int xa, input int xb, input int ya, input int yb,
                           input bit typed, input int v, input int sx, input int sy,
                           input int pr);
        touch_row_t row;
        row.sel      = sel;
        row.s.z1     = z1;
        row.s.z2     = z2;
        row.s.px     = px;
        row.s.xa     = xa;
        row.s.xb     = xb;
        row.s.ya     = ya;
        row.s.yb     = yb;
        row.typed    = typed;
        row.res.valid = v;
        row.res.sx   = sx;
        row.res.sy   = sy;
        row.res.pr   = pr;
        touch_rows.push_back(row);
    endtask

    task automatic send_set(input sample_set_t s, input bit typed, input touch_res_t res);
        touch_tag_t tag;
        tag.typed = typed;
        tag.res   = res;
        set_tags.push_back(tag);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        sets_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (touches_seen != sets_sent) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_regs(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_RES;
        i_cfg_wdata <= c.res;
        @(posedge i_clk);
        i_cfg_addr  <= REG_PORT;
        i_cfg_wdata <= ($urandom << 1) | c.portrait;
        @(posedge i_clk);
        i_cfg_addr  <= REG_X_MIN;
        i_cfg_wdata <= ($urandom << S_W) | c.x_min;
        @(posedge i_clk);
        i_cfg_addr  <= REG_X_MAX;
        i_cfg_wdata <= ($urandom << S_W) | c.x_max;
        @(posedge i_clk);
        i_cfg_addr  <= REG_Y_MIN;
        i_cfg_wdata <= ($urandom << S_W) | c.y_min;
        @(posedge i_clk);
        i_cfg_addr  <= REG_Y_MAX;
        i_cfg_wdata <= ($urandom << S_W) | c.y_max;
        @(posedge i_clk);
        i_cfg_addr  <= REG_VOID_A;
        i_cfg_wdata <= $urandom;
        @(posedge i_clk);
        i_cfg_addr  <= REG_VOID_B;
        i_cfg_wdata <= $urandom;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off once for a long stretch, keep ready high when calm, otherwise stall in short bursts
    always @(posedge i_clk) begin
        if (hold_start && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            rx_left       <= $urandom_range(0, 9);
        end else begin
            m_axis_tready <= 1'b1;
            rx_left       <= $urandom_range(0, 40);
        end
    end

    always @(posedge i_clk) begin : scoreboard
        touch_tag_t  tag;
        touch_res_t  due;
        touch_res_t  got;
        sample_set_t acc;
        if (!i_rst_n) begin
            model_cfg.res      = RST_RES;
            model_cfg.portrait = RST_PORT;
            model_cfg.x_min    = RST_X_MIN;
            model_cfg.x_max    = RST_X_MAX;
            model_cfg.y_min    = RST_Y_MIN;
            model_cfg.y_max    = RST_Y_MAX;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RES:   model_cfg.res      = i_cfg_wdata;
                    REG_PORT:  model_cfg.portrait = i_cfg_wdata[0];
                    REG_X_MIN: model_cfg.x_min    = i_cfg_wdata[S_W-1:0];
                    REG_X_MAX: model_cfg.x_max    = i_cfg_wdata[S_W-1:0];
                    REG_Y_MIN: model_cfg.y_min    = i_cfg_wdata[S_W-1:0];
                    REG_Y_MAX: model_cfg.y_max    = i_cfg_wdata[S_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                touches_seen++;
                got.valid = m_axis_tuser[0];
                got.sx    = m_axis_tdata[S_W-1:0];
                got.sy    = m_axis_tdata[2*S_W-1:S_W];
                got.pr    = m_axis_tdata[2*S_W+P_W-1:2*S_W];
                if (touches_due.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected transaction: v=%0d x=%0d y=%0d p=%0d",
                                 got.valid, got.sx, got.sy, got.pr);
                end else begin
                    due = touches_due.pop_front();
                    if (got.valid !== due.valid || got.sx !== due.sx ||
                        got.sy !== due.sy || got.pr !== due.pr) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("mismatch: exp v=%0d x=%0d y=%0d p=%0d, got v=%0d x=%0d y=%0d p=%0d",
                                     due.valid, due.sx, due.sy, due.pr,
                                     got.valid, got.sx, got.sy, got.pr);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                acc = s_axis_tdata[$bits(sample_set_t)-1:0];
                tag = set_tags.pop_front();
                if (tag.typed)
                    touches_due.push_back(tag.res);
                else
                    touches_due.push_back(predict_touch(model_cfg, acc));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int          cur_sel;
        t_cfg        phase_cfg;
        touch_res_t  none;
        none = '0;

        dir_cfg[0] = {RST_RES, RST_PORT, RST_X_MIN, RST_X_MAX, RST_Y_MIN, RST_Y_MAX};
        dir_cfg[1] = {16'hFFFF, 1'b0, 10'd0, 10'd890, 10'd15, 10'd845};
        dir_cfg[2] = {16'd1, 1'b1, 10'd0, 10'd1023, 10'd0, 10'd1023};
        dir_cfg[3] = {16'd0, 1'b0, 10'd500, 10'd500, 10'd0, 10'd1023};
        dir_cfg[4] = {16'd0, 1'b1, 10'd0, 10'd1023, 10'd600, 10'd100};

        // register defaults after reset, simple pressure, portrait
        add_row(0,    0,    0,    0,    0,    0,    0,    0, 1, 0,   0,   0,     0);
        add_row(0,    0,    0,    0, 1023, 1023, 1008, 1008, 1, 1,   0, 240,  1023);
        add_row(0, 1023,    0,    0,  133,  133,  178,  178, 1, 1, 320,   0,  2046);
        add_row(0,    0, 1023,    0, 1023, 1023, 1008, 1008, 1, 0,   0,   0,     0);
        add_row(0,    0,    0,    0, 1023, 1022, 1008, 1008, 1, 0,   0,   0,     0);
        add_row(0,    0,    0,    0, 1023, 1023, 1008, 1000, 1, 0,   0,   0,     0);
        add_row(0,    0,    0,    0, 1023, 1023, 1009, 1009, 1, 0,   0,   0,     0);
        add_row(0, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1, 0,   0,   0,     0);
        add_row(0,  300,  400,  512,  600,  600,  500,  500, 0, 0,   0,   0,     0);
        // resistance formula, landscape
        add_row(1,    0,  500,    0, 1023, 1023, 1008, 1008, 1, 0,   0,   0,     0);
        add_row(1,  600,  500,    0, 1023, 1023, 1008, 1008, 1, 0,   0,   0,     0);
        add_row(1,  500,  500,    0, 1023, 1023, 1008, 1008, 1, 0,   0,   0,     0);
        add_row(1,    1, 1023,    0, 1023, 1023, 1008, 1008, 1, 1,   0,   0, 65535);
        add_row(1,    1, 1023,    0,  133,  133,  178,  178, 1, 1, 240, 320, 65535);
        add_row(1,  700,  900,  300,  400,  400,  450,  450, 0, 0,   0,   0,     0);
        add_row(1, 1022, 1023, 1023, 1023, 1023, 1008, 1008, 1, 0,   0,   0,     0);
        // smallest resistance, full window
        add_row(2, 1022, 1023, 1022, 1023, 1023, 1023, 1023, 1, 0,   0,   0,     0);
        add_row(2,    1, 1023,    0, 1023, 1023, 1023, 1023, 0, 0,   0,   0,     0);
        add_row(2,    1, 1023,    0,    0,    0,    0,    0, 0, 0,   0,   0,     0);
        add_row(2,  200,  800,  100,  700,  700,  300,  300, 0, 0,   0,   0,     0);
        // empty windows
        add_row(3,    0,    0,    0,  523,  523,  500,  500, 1, 0,   0,   0,     0);
        add_row(4,    0,    0,    0,  500,  500,  523,  523, 1, 0,   0,   0,     0);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_sel = RESET_SEL;
        foreach (touch_rows[i]) begin
            if (touch_rows[i].sel != cur_sel) begin
                drain();
                cur_sel = touch_rows[i].sel;
                write_regs(dir_cfg[cur_sel]);
            end
            send_set(touch_rows[i].s, touch_rows[i].typed, touch_rows[i].res);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            phase_cfg = rand_cfg();
            write_regs(phase_cfg);
            if (ph == HOLD_PHASE)
                hold_start <= 1'b1;
            if (ph == RAND_PHASES - 1)
                calm <= 1'b1;
            repeat (SETS_PER_PHASE) send_set(rand_set(phase_cfg), 1'b0, none);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && touches_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/rtpc_pkg.sv
src/resistive_touch_point_calc_unit.sv
bench/resistive_touch_point_calc_unit_tb.sv
